@@ rtl/swbi_pkg.sv @@
// Package for the stack with bottom insert: command and status codes,
// controller states and default sizes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package swbi_pkg;

    // Default sizes for the top level
    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed width of the value fields on the ports
    localparam int VALUE_W = 32;

    typedef enum logic [1:0] {
        CMD_PUSH_TOP    = 2'd0,
        CMD_POP_TOP     = 2'd1,
        CMD_PUSH_BOTTOM = 2'd2,
        CMD_READ        = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_POP_WAIT
    } state_t;

endpackage

`default_nettype wire

@@ rtl/swbi_if.sv @@
// Valid/ready channel interfaces for the command words and the result words.
// Depends on nothing; widths of the value fields are fixed at 32 bits.
`timescale 1ns / 1ps
`default_nettype none

interface swbi_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic signed [31:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface swbi_res_if #(
    parameter int CNT_W = 7
);
    logic               valid;
    logic               ready;
    logic signed [31:0] top_value;
    logic signed [31:0] bottom_value;
    logic [CNT_W-1:0]   height;
    logic               is_empty;
    logic [1:0]         status;

    modport source (output valid, output top_value, output bottom_value, output height,
                    output is_empty, output status, input ready);
    modport sink   (input valid, input top_value, input bottom_value, input height,
                    input is_empty, input status, output ready);
endinterface

`default_nettype wire

@@ rtl/swbi_store.sv @@
// Entry store of the ring buffer: one write port, one read port, registered
// read data. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module swbi_store #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32,
    localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  clk,
    input  wire logic                  we,
    input  wire logic [PTR_W-1:0]      waddr,
    input  wire logic [DATA_WIDTH-1:0] wdata,
    input  wire logic                  re,
    input  wire logic [PTR_W-1:0]      raddr,
    output logic      [DATA_WIDTH-1:0] rdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read one entry, data valid next cycle
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/swbi_ctrl.sv @@
// Controller of the stack with bottom insert: pointers, count, cached top and
// bottom entries, and the read of the new top after a pop.
// Depends on swbi_pkg and swbi_store.
`timescale 1ns / 1ps
`default_nettype none

module swbi_ctrl
    import swbi_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W     = $clog2(DEPTH + 1)
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cmd_valid,
    output logic                       cmd_ready,
    input  wire logic [1:0]            cmd_command,
    input  wire logic [VALUE_W-1:0]    cmd_value,
    input  wire logic                  out_free,
    output logic                       res_load,
    output logic      [DATA_WIDTH-1:0] res_top,
    output logic      [DATA_WIDTH-1:0] res_bot,
    output logic      [CNT_W-1:0]      res_cnt,
    output status_t                    res_status
);

    state_t                state_reg, state_next;
    logic [PTR_W-1:0]      top_ptr_reg, top_ptr_next;
    logic [PTR_W-1:0]      bot_ptr_reg, bot_ptr_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DATA_WIDTH-1:0] top_val_reg, top_val_next;
    logic [DATA_WIDTH-1:0] bot_val_reg, bot_val_next;

    logic                  mem_we;
    logic [PTR_W-1:0]      mem_waddr;
    logic                  mem_re;
    logic [DATA_WIDTH-1:0] mem_rdata;
    logic [DATA_WIDTH-1:0] val_st;
    logic [63:0]           val_wide;
    logic [PTR_W-1:0]      top_inc;
    logic [PTR_W-1:0]      top_dec;
    logic [PTR_W-1:0]      bot_dec;
    logic                  accept;
    cmd_t                  cmd;

    // Pointer steps, wrapping modulo DEPTH
    assign top_inc = (top_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : top_ptr_reg + 1'b1;
    assign top_dec = (top_ptr_reg == '0) ? PTR_W'(DEPTH - 1) : top_ptr_reg - 1'b1;
    assign bot_dec = (bot_ptr_reg == '0) ? PTR_W'(DEPTH - 1) : bot_ptr_reg - 1'b1;

    // Keep the low DATA_WIDTH bits of the value word
    assign val_wide = {32'd0, cmd_value};
    assign val_st   = DATA_WIDTH'(val_wide);

    assign cmd    = cmd_t'(cmd_command);
    assign accept = cmd_valid && cmd_ready;

    // A pop reads only an entry written by an earlier word, and no write is
    // issued in the same cycle, so read and write never collide
    swbi_store #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (val_st),
        .re    (mem_re),
        .raddr (top_dec),
        .rdata (mem_rdata)
    );

    // Hold state, pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            top_ptr_reg <= '0;
            bot_ptr_reg <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            top_ptr_reg <= top_ptr_next;
            bot_ptr_reg <= bot_ptr_next;
            cnt_reg     <= cnt_next;
        end
    end

    // Cached end entries, meaningful only while not empty
    always_ff @(posedge clk)
    begin
        top_val_reg <= top_val_next;
        bot_val_reg <= bot_val_next;
    end

    // Decode the command word and advance the pointers
    always_comb
    begin
        state_next   = state_reg;
        top_ptr_next = top_ptr_reg;
        bot_ptr_next = bot_ptr_reg;
        cnt_next     = cnt_reg;
        top_val_next = top_val_reg;
        bot_val_next = bot_val_reg;
        mem_we       = 1'b0;
        mem_waddr    = top_ptr_reg;
        mem_re       = 1'b0;
        res_load     = 1'b0;
        res_status   = ST_OK;
        cmd_ready    = (state_reg == S_IDLE) && out_free;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_load = 1'b1;
                    case (cmd)
                        CMD_PUSH_TOP, CMD_PUSH_BOTTOM:
                        begin
                            if (cnt_reg == CNT_W'(DEPTH))
                            begin
                                res_status = ST_PUSH_FULL;
                            end
                            else if (cnt_reg == '0)
                            begin
                                mem_we       = 1'b1;
                                mem_waddr    = top_ptr_reg;
                                bot_ptr_next = top_ptr_reg;
                                top_val_next = val_st;
                                bot_val_next = val_st;
                                cnt_next     = CNT_W'(1);
                            end
                            else if (cmd == CMD_PUSH_TOP)
                            begin
                                mem_we       = 1'b1;
                                mem_waddr    = top_inc;
                                top_ptr_next = top_inc;
                                top_val_next = val_st;
                                cnt_next     = cnt_reg + 1'b1;
                            end
                            else
                            begin
                                mem_we       = 1'b1;
                                mem_waddr    = bot_dec;
                                bot_ptr_next = bot_dec;
                                bot_val_next = val_st;
                                cnt_next     = cnt_reg + 1'b1;
                            end
                        end
                        CMD_POP_TOP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_status = ST_POP_EMPTY;
                            end
                            else if (cnt_reg == CNT_W'(1))
                            begin
                                cnt_next = '0;
                            end
                            else
                            begin
                                // Fetch the new top, report it next cycle
                                mem_re       = 1'b1;
                                res_load     = 1'b0;
                                top_ptr_next = top_dec;
                                cnt_next     = cnt_reg - 1'b1;
                                state_next   = S_POP_WAIT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_POP_WAIT:
            begin
                res_load     = 1'b1;
                top_val_next = mem_rdata;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res_top = top_val_next;
    assign res_bot = bot_val_next;
    assign res_cnt = cnt_next;

endmodule

`default_nettype wire

@@ rtl/stack_with_bottom_insert.sv @@
// Channel  Dir  Fields                                              Handshake
// cmd      in   command[1:0], value[31:0]                           valid/ready
// res      out  top_value, bottom_value, height, is_empty, status   valid/ready
//
// Push, read-only, a pop on an empty stack and a pop of the last entry are
// handled in the idle state alone. A pop that leaves one or more entries also
// passes the wait state: the new top comes from the entry store through its
// registered read port, and no command word is taken in the wait state.
// Reset clears pointers, count and the output valid flag; the store is not
// cleared. A result word waits in the output register; a new command word is
// taken in the cycle that word leaves, or whenever the register is empty, outside the wait state.
// Top level of the stack with bottom insert. Depends on swbi_pkg, swbi_if
// and swbi_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module stack_with_bottom_insert
    import swbi_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int CNT_W     = $clog2(DEPTH + 1)
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    swbi_cmd_if.sink    cmd,
    swbi_res_if.source  res
);

    logic                  out_free;
    logic                  res_load;
    logic [DATA_WIDTH-1:0] res_top;
    logic [DATA_WIDTH-1:0] res_bot;
    logic [CNT_W-1:0]      res_cnt;
    status_t               res_status;

    logic                  valid_reg;
    logic [VALUE_W-1:0]    top_reg, top_next;
    logic [VALUE_W-1:0]    bot_reg, bot_next;
    logic [CNT_W-1:0]      height_reg;
    status_t               status_reg;
    logic signed [63:0]    top_ext;
    logic signed [63:0]    bot_ext;

    assign out_free = !valid_reg || res.ready;

    swbi_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd.valid),
        .cmd_ready   (cmd.ready),
        .cmd_command (cmd.command),
        .cmd_value   (cmd.value),
        .out_free    (out_free),
        .res_load    (res_load),
        .res_top     (res_top),
        .res_bot     (res_bot),
        .res_cnt     (res_cnt),
        .res_status  (res_status)
    );

    // Sign-extend the stored entries; report zero when empty
    always_comb
    begin
        top_ext  = 64'(signed'(res_top));
        bot_ext  = 64'(signed'(res_bot));
        top_next = (res_cnt == '0) ? '0 : top_ext[VALUE_W-1:0];
        bot_next = (res_cnt == '0) ? '0 : bot_ext[VALUE_W-1:0];
    end

    // Hold the result word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            top_reg    <= top_next;
            bot_reg    <= bot_next;
            height_reg <= res_cnt;
            status_reg <= res_status;
        end
    end

    assign res.valid        = valid_reg;
    assign res.top_value    = top_reg;
    assign res.bottom_value = bot_reg;
    assign res.height       = height_reg;
    assign res.is_empty     = (height_reg == '0);
    assign res.status       = status_reg;

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for stack_with_bottom_insert: drives command words,
// mirrors the stack in a local model and checks every result word.
// Depends on swbi_pkg, swbi_if and the RTL of the block.
`timescale 1ns / 1ps

module tb;
    import swbi_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int DW           = DATA_WIDTH_DEF;
    localparam int PTR_W        = $clog2(DEPTH);
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int RANDOM_WORDS = 1350;
    localparam int TAIL_CYCLES  = 10;
    localparam int CYCLE_LIMIT  = 500000;

    typedef struct {
        cmd_t                 op;
        logic [VALUE_W-1:0]   data;
        int unsigned          gap;
        bit                   hold;   // wait for every result before sending
    } cmd_word_t;

    typedef struct {
        logic signed [VALUE_W-1:0] top_value;
        logic signed [VALUE_W-1:0] bottom_value;
        logic [CNT_W-1:0]          height;
        logic                      is_empty;
        status_t                   status;
    } report_t;

    logic clk;
    logic rst_n;

    swbi_cmd_if               cmd_ch ();
    swbi_res_if #(.CNT_W(CNT_W)) res_ch ();

    stack_with_bottom_insert u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    // Mirror of the stack contents and pointers
    logic [DW-1:0]    mirror_store [DEPTH];
    logic [PTR_W-1:0] mirror_top;
    logic [PTR_W-1:0] mirror_bottom;
    int unsigned      mirror_count;

    cmd_word_t   cmd_words [$];
    report_t     expected_reports [$];

    bit          cmd_taken;
    bit          res_taken;
    bit          cmd_busy;
    bit          gap_loaded;
    int unsigned cmd_wait;
    int unsigned res_wait;
    bit          res_burst;
    int unsigned res_seen;
    int unsigned mismatch_count;
    int unsigned cycle_count;
    int unsigned op_seen [4];
    int unsigned pop_empty_seen;
    int unsigned push_full_seen;
    int unsigned peak_height;

    function automatic logic [PTR_W-1:0] ptr_prev(logic [PTR_W-1:0] p);
        return (p == 0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
    endfunction

    function automatic logic signed [VALUE_W-1:0] entry_at(logic [PTR_W-1:0] p);
        return VALUE_W'($signed(mirror_store[p]));
    endfunction

    // Apply one command word to the mirror and build the result it should give
    function automatic report_t predict_report(cmd_t op, logic [VALUE_W-1:0] data);
        report_t r;
        r.status = ST_OK;
        case (op)
            CMD_PUSH_TOP, CMD_PUSH_BOTTOM:
            begin
                if (mirror_count >= DEPTH)
                    r.status = ST_PUSH_FULL;
                else if (mirror_count == 0)
                begin
                    mirror_store[mirror_top] = data[DW-1:0];
                    mirror_bottom = mirror_top;
                    mirror_count = 1;
                end
                else if (op == CMD_PUSH_TOP)
                begin
                    mirror_top = (mirror_top == PTR_W'(DEPTH - 1)) ? '0 : mirror_top + 1'b1;
                    mirror_store[mirror_top] = data[DW-1:0];
                    mirror_count++;
                end
                else
                begin
                    mirror_bottom = ptr_prev(mirror_bottom);
                    mirror_store[mirror_bottom] = data[DW-1:0];
                    mirror_count++;
                end
            end
            CMD_POP_TOP:
            begin
                if (mirror_count == 0)
                    r.status = ST_POP_EMPTY;
                else
                begin
                    // the last entry leaves both pointers in place
                    if (mirror_count > 1)
                        mirror_top = ptr_prev(mirror_top);
                    mirror_count--;
                end
            end
            default:
            begin
            end
        endcase
        r.top_value    = (mirror_count == 0) ? '0 : entry_at(mirror_top);
        r.bottom_value = (mirror_count == 0) ? '0 : entry_at(mirror_bottom);
        r.height       = CNT_W'(mirror_count);
        r.is_empty     = (mirror_count == 0);
        return r;
    endfunction

    task automatic check_field(string field, logic signed [63:0] want, logic signed [63:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch in %s of result %0d: expected %0d, got %0d",
                         field, res_seen, want, got);
        end
    endtask

    task automatic add_word(cmd_t op, logic [VALUE_W-1:0] data, int unsigned gap, bit hold);
        cmd_word_t w;
        w.op   = op;
        w.data = data;
        w.gap  = gap;
        w.hold = hold;
        cmd_words.push_back(w);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 32'h7fff_ffff;
            3: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Timeout
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_reports.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Drive command words: wait out each word's gap, then hold valid until taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_busy && cmd_taken)
            begin
                void'(cmd_words.pop_front());
                cmd_busy = 1'b0;
            end
            cmd_taken = 1'b0;
            if (!cmd_busy && cmd_words.size() > 0)
            begin
                if (!gap_loaded)
                begin
                    cmd_wait   = cmd_words[0].gap;
                    gap_loaded = 1'b1;
                end
                if (cmd_wait > 0)
                    cmd_wait--;
                else if (!(cmd_words[0].hold && expected_reports.size() != 0))
                begin
                    cmd_busy   = 1'b1;
                    gap_loaded = 1'b0;
                    cmd_ch.command <= cmd_words[0].op;
                    cmd_ch.value   <= cmd_words[0].data;
                end
            end
            cmd_ch.valid <= cmd_busy;
        end
    end

    // Drive ready: after each result word, stall for a random wait, or not at all in a burst
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (res_taken)
            begin
                res_taken = 1'b0;
                if (res_seen % 50 == 0)
                    res_burst = ($urandom_range(0, 3) == 0);
                res_wait = res_burst ? 0 : $urandom_range(0, 15);
            end
            else if (res_wait > 0)
                res_wait--;
            res_ch.ready <= (res_wait == 0);
        end
    end

    // Monitor both channels: check result words, then predict for new commands
    always @(posedge clk)
    begin
        report_t want;
        report_t got;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                res_taken = 1'b1;
                res_seen++;
                if (expected_reports.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result %0d arrived with nothing expected", res_seen);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("top_value", want.top_value, res_ch.top_value);
                    check_field("bottom_value", want.bottom_value, res_ch.bottom_value);
                    check_field("height", want.height, res_ch.height);
                    check_field("is_empty", want.is_empty, res_ch.is_empty);
                    check_field("status", want.status, res_ch.status);
                end
            end
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                cmd_taken = 1'b1;
                got = predict_report(cmd_t'(cmd_ch.command), cmd_ch.value);
                expected_reports.push_back(got);
                op_seen[cmd_ch.command]++;
                if (got.status == ST_POP_EMPTY)
                    pop_empty_seen++;
                if (got.status == ST_PUSH_FULL)
                    push_full_seen++;
                if (got.height > peak_height)
                    peak_height = got.height;
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        int unsigned kind;
        int unsigned span;
        int unsigned roll;
        int unsigned total;
        bit          burst;
        cmd_t        op;

        rst_n          = 1'b0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.command = CMD_READ;
        cmd_ch.value   = '0;
        res_ch.ready   = 1'b0;
        mirror_top     = '0;
        mirror_bottom  = '0;
        mirror_count   = 0;

        // Directed: empty stack, extremes, pops down to empty, bottom pushes
        add_word(CMD_READ,        32'h0000_0000, 0, 1'b0);
        add_word(CMD_POP_TOP,     32'h1234_5678, 0, 1'b0);
        add_word(CMD_PUSH_TOP,    32'h7fff_ffff, 0, 1'b0);
        add_word(CMD_PUSH_BOTTOM, 32'h8000_0000, 0, 1'b0);
        add_word(CMD_READ,        32'hffff_ffff, 0, 1'b0);
        add_word(CMD_PUSH_TOP,    32'h0000_0000, 0, 1'b0);
        add_word(CMD_PUSH_BOTTOM, 32'hffff_ffff, 0, 1'b0);
        add_word(CMD_POP_TOP,     32'h0000_0000, 0, 1'b0);
        add_word(CMD_POP_TOP,     32'h0000_0000, 3, 1'b0);
        add_word(CMD_POP_TOP,     32'h0000_0000, 0, 1'b0);
        add_word(CMD_POP_TOP,     32'h0000_0000, 0, 1'b0);
        add_word(CMD_POP_TOP,     32'hffff_ffff, 0, 1'b0);
        add_word(CMD_PUSH_BOTTOM, 32'h5555_5555, 0, 1'b0);
        add_word(CMD_PUSH_BOTTOM, 32'haaaa_aaaa, 0, 1'b0);
        add_word(CMD_PUSH_TOP,    32'h0000_0001, 0, 1'b0);
        add_word(CMD_READ,        32'hdead_beef, 0, 1'b0);
        add_word(CMD_POP_TOP,     32'hcafe_f00d, 0, 1'b0);
        add_word(CMD_POP_TOP,     32'h0000_0000, 0, 1'b0);
        add_word(CMD_POP_TOP,     32'h0000_0000, 0, 1'b0);
        add_word(CMD_POP_TOP,     32'h0000_0000, 0, 1'b0);

        // Random phases: fill to full, drain to empty, or mix
        total = 0;
        while (total < RANDOM_WORDS)
        begin
            kind  = $urandom_range(0, 2);
            span  = (kind == 2) ? $urandom_range(20, 80) : $urandom_range(80, 140);
            burst = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < span; i++)
            begin
                roll = $urandom_range(0, 99);
                case (kind)
                    0: op = (roll < 45) ? CMD_PUSH_TOP : (roll < 88) ? CMD_PUSH_BOTTOM :
                            (roll < 95) ? CMD_POP_TOP : CMD_READ;
                    1: op = (roll < 80) ? CMD_POP_TOP : (roll < 88) ? CMD_PUSH_TOP :
                            (roll < 95) ? CMD_PUSH_BOTTOM : CMD_READ;
                    default: op = (roll < 30) ? CMD_PUSH_TOP : (roll < 55) ? CMD_PUSH_BOTTOM :
                                  (roll < 85) ? CMD_POP_TOP : CMD_READ;
                endcase
                add_word(op, pick_value(), burst ? 0 : $urandom_range(0, 15),
                         (i == 0) && (total == 0 || $urandom_range(0, 3) == 0));
            end
            total += span;
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (cmd_words.size() != 0 || expected_reports.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d push top, %0d pop, %0d push bottom, %0d read words",
                 op_seen[CMD_PUSH_TOP], op_seen[CMD_POP_TOP],
                 op_seen[CMD_PUSH_BOTTOM], op_seen[CMD_READ]);
        $display("peak height %0d, %0d pops on empty, %0d pushes when full, %0d mismatches",
                 peak_height, pop_empty_seen, push_full_seen, mismatch_count);
        if (mismatch_count == 0 && expected_reports.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
